@@ sv/xrg_pkg.sv @@
// shared types and constants for the xorshift64* range generator
`default_nettype none

package xrg_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ShiftA = 12;
  localparam int unsigned ShiftB = 25;
  localparam int unsigned ShiftC = 27;
  localparam int unsigned WarmupSteps = 4;

  localparam logic [WordW-1:0] MixMultHi = 32'h2545_F491;
  localparam logic [WordW-1:0] MixMultLo = 32'h4F6C_DD1D;

  typedef enum logic [1:0] {
    KIND_RESEED = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_RANGE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_LOW  = 2'd1,
    RES_ACC  = 2'd2,
    RES_MOD  = 2'd3
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_WARM_RST,
    ST_IDLE,
    ST_DECODE,
    ST_WARM,
    ST_DIV_LIMIT,
    ST_LIMIT,
    ST_MUL,
    ST_CHECK,
    ST_DIV_MOD,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic     capture;
    logic     reseed;
    logic     step;
    logic     count_inc;
    logic     mul_run;
    logic     div_start;
    logic     div_src_acc;
    logic     div_run;
    logic     limit_load;
    logic     out_load;
    res_sel_e res_sel;
  } xrg_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       mul_last;
    logic       div_last;
    logic       reject;
    logic       out_free;
  } xrg_status_t;

  function automatic logic [StateW-1:0] xs_step(input logic [StateW-1:0] s);
    logic [StateW-1:0] s1;
    logic [StateW-1:0] s2;
    s1 = s ^ (s >> ShiftA);
    s2 = s1 ^ (s1 << ShiftB);
    return s2 ^ (s2 >> ShiftC);
  endfunction

endpackage

`default_nettype wire

@@ sv/xrg_datapath.sv @@
// generator state, shared multiplier, bit-serial remainder unit and result register
`default_nettype none

module xrg_datapath import xrg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xrg_cmd_t          cmd_i,
  output      xrg_status_t       status_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [WordW-1:0]  seed_value_i,
  input  wire logic [WordW-1:0]  range_low_i,
  input  wire logic [WordW-1:0]  range_high_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [WordW-1:0]  value_o,
  output      logic [StateW-1:0] state_hash_o
);

  // captured request
  logic [1:0]       kind_q;
  logic [WordW-1:0] seed_in_q;
  logic [WordW-1:0] low_q;
  logic [WordW-1:0] span_q;
  logic             empty_q;

  // architectural state
  logic [StateW-1:0] state_q;
  logic [WordW-1:0]  seed_q;
  logic [WordW-1:0]  count_q;

  // multiplier
  logic [1:0]        mul_ph_q;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [WordW-1:0]  mul_a, mul_b;
  logic [2*WordW-1:0] prod;

  // remainder unit
  logic [WordW-1:0]  rem_q, rem_d;
  logic [WordW-1:0]  dvd_q;
  logic [4:0]        div_cnt_q;
  logic [WordW:0]    rem_sh;
  logic [WordW-1:0]  limit_q;

  // result register
  logic              out_valid_q;
  logic [WordW-1:0]  value_q, res_val;
  logic [StateW-1:0] hash_q;
  logic [WordW-1:0]  seed_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      seed_in_q <= seed_value_i;
      low_q     <= range_low_i;
      span_q    <= range_high_i - range_low_i;
      empty_q   <= (range_low_i >= range_high_i);
    end
  end

  assign seed_eff = (seed_in_q == '0) ? WordW'(1) : seed_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateW'(1);
      seed_q  <= WordW'(1);
      count_q <= '0;
    end else if (cmd_i.reseed) begin
      state_q <= {{(StateW-WordW){1'b0}}, seed_eff};
      seed_q  <= seed_eff;
      count_q <= '0;
    end else if (cmd_i.step) begin
      state_q <= xs_step(state_q);
      if (cmd_i.count_inc) begin
        count_q <= count_q + WordW'(1);
      end
    end
  end

  // high word of the low 64 bits of state * mult, one partial product a cycle
  assign mul_a = (mul_ph_q == 2'd1) ? state_q[StateW-1:WordW] : state_q[WordW-1:0];
  assign mul_b = (mul_ph_q == 2'd2) ? MixMultHi : MixMultLo;
  assign prod  = mul_a * mul_b;

  always_comb begin
    if (mul_ph_q == 2'd0) begin
      acc_d = prod[2*WordW-1:WordW];
    end else begin
      acc_d = acc_q + prod[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ph_q <= '0;
    end else if (cmd_i.mul_run) begin
      mul_ph_q <= (mul_ph_q == 2'd2) ? 2'd0 : mul_ph_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_run) begin
      acc_q <= acc_d;
    end
  end

  // restoring remainder, one dividend bit a cycle
  assign rem_sh = {rem_q, dvd_q[WordW-1]};

  always_comb begin
    if (rem_sh >= {1'b0, span_q}) begin
      rem_d = WordW'(rem_sh - {1'b0, span_q});
    end else begin
      rem_d = rem_sh[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_run) begin
      div_cnt_q <= div_cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dvd_q <= cmd_i.div_src_acc ? acc_q : '1;
    end else if (cmd_i.div_run) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[WordW-2:0], 1'b0};
    end
    if (cmd_i.limit_load) begin
      limit_q <= ~rem_q;
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_ZERO: res_val = '0;
      RES_LOW:  res_val = low_q;
      RES_ACC:  res_val = acc_q;
      RES_MOD:  res_val = low_q + rem_q;
      default:  res_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      value_q <= res_val;
      hash_q  <= state_q ^ {seed_q, {WordW{1'b0}}} ^ {{(StateW-WordW){1'b0}}, count_q};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign state_hash_o = hash_q;

  assign status_o.kind     = kind_q;
  assign status_o.empty    = empty_q;
  assign status_o.mul_last = (mul_ph_q == 2'd2);
  assign status_o.div_last = (div_cnt_q == 5'd31);
  assign status_o.reject   = (acc_q >= limit_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  a_seed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q != '0) else $error("stored seed became zero");

  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != '0) else $error("generator state became zero");

  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_ph_q != 2'd3) else $error("multiplier phase out of range");

endmodule

`default_nettype wire

@@ sv/xrg_ctrl.sv @@
// sequencing state machine for the xorshift64* range generator
`default_nettype none

module xrg_ctrl import xrg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire xrg_status_t status_i,
  output      xrg_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  warm_q;
  logic        warm_last;

  assign warm_last = (warm_q == 2'(WarmupSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WARM_RST;
      warm_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_WARM || state_q == ST_WARM_RST) begin
        warm_q <= warm_q + 2'd1;
      end else begin
        warm_q <= '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WARM_RST: if (warm_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        case (status_i.kind)
          KIND_RESEED: state_d = ST_WARM;
          KIND_RAW:    state_d = ST_MUL;
          KIND_RANGE:  state_d = status_i.empty ? ST_FINISH : ST_DIV_LIMIT;
          default:     state_d = ST_FINISH;
        endcase
      end
      ST_WARM:      if (warm_last) state_d = ST_FINISH;
      ST_DIV_LIMIT: if (status_i.div_last) state_d = ST_LIMIT;
      ST_LIMIT:     state_d = ST_MUL;
      ST_MUL:       if (status_i.mul_last) state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.kind == KIND_RAW) begin
          state_d = ST_FINISH;
        end else if (status_i.reject) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DIV_MOD;
        end
      end
      ST_DIV_MOD:   if (status_i.div_last) state_d = ST_FINISH;
      ST_FINISH:    if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_sel = RES_ZERO;
    case (state_q)
      ST_WARM_RST: cmd_o.step = 1'b1;
      ST_IDLE:     cmd_o.capture = in_valid_i;
      ST_DECODE: begin
        case (status_i.kind)
          KIND_RESEED: cmd_o.reseed = 1'b1;
          KIND_RAW: begin
            cmd_o.step      = 1'b1;
            cmd_o.count_inc = 1'b1;
          end
          KIND_RANGE:  cmd_o.div_start = !status_i.empty;
          default:     cmd_o.capture = 1'b0;
        endcase
      end
      ST_WARM:      cmd_o.step = 1'b1;
      ST_DIV_LIMIT: cmd_o.div_run = 1'b1;
      ST_LIMIT: begin
        cmd_o.limit_load = 1'b1;
        cmd_o.step       = 1'b1;
        cmd_o.count_inc  = 1'b1;
      end
      ST_MUL:       cmd_o.mul_run = 1'b1;
      ST_CHECK: begin
        if (status_i.kind != KIND_RAW) begin
          if (status_i.reject) begin
            cmd_o.step      = 1'b1;
            cmd_o.count_inc = 1'b1;
          end else begin
            cmd_o.div_start   = 1'b1;
            cmd_o.div_src_acc = 1'b1;
          end
        end
      end
      ST_DIV_MOD:   cmd_o.div_run = 1'b1;
      ST_FINISH: begin
        cmd_o.out_load = status_i.out_free;
        case (status_i.kind)
          KIND_RESEED: cmd_o.res_sel = RES_ZERO;
          KIND_RAW:    cmd_o.res_sel = RES_ACC;
          KIND_RANGE:  cmd_o.res_sel = status_i.empty ? RES_LOW : RES_MOD;
          default:     cmd_o.res_sel = RES_ZERO;
        endcase
      end
      default:      cmd_o.capture = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free) else $error("result loaded over a waiting one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second request taken too early");

  a_step_not_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_run |-> !cmd_o.step && !cmd_o.mul_run) else $error("state moved during remainder");

endmodule

`default_nettype wire

@@ sv/xorshift64star_range_generator.sv @@
// top level of the xorshift64* range generator: controller plus datapath
// work: a ranged draw runs two bit-serial remainder passes and the shared 32x32 multiplier,
//   which repeats with a fresh step for each rejected draw; one request is in work at a time
// the next request is taken in the cycle after the result is registered
// reset: state reloads seed one and runs 4 warm-up steps, stall held high meanwhile
`default_nettype none

module xorshift64star_range_generator import xrg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [WordW-1:0]  seed_value_i,
  input  wire logic [WordW-1:0]  range_low_i,
  input  wire logic [WordW-1:0]  range_high_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [WordW-1:0]  value_o,
  output      logic [StateW-1:0] state_hash_o
);

  // command and status bundles between the sequencer and the datapath
  xrg_cmd_t    cmd;
  xrg_status_t status;

  // sequencer: decodes the request kind, runs warm-up, redraw and remainder loops
  xrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: state, multiplier, remainder unit and the result register that
  // lets a finished result wait while the next request is taken
  xrg_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .kind_i       (kind_i),
    .seed_value_i (seed_value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .state_hash_o (state_hash_o)
  );

endmodule

`default_nettype wire

@@ bench/xrg_draw_checker.sv @@
// checker for the xorshift64* range generator: watches both channels, predicts and compares
`default_nettype none

module xrg_draw_checker import xrg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [1:0]        kind_i,
  input  wire logic [WordW-1:0]  seed_value_i,
  input  wire logic [WordW-1:0]  range_low_i,
  input  wire logic [WordW-1:0]  range_high_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [WordW-1:0]  value_i,
  input  wire logic [StateW-1:0] state_hash_i,
  output      int                fail_count_o,
  output      int                pending_o,
  output      int                checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WordW-1:0]  value;
    logic [StateW-1:0] hash;
  } draw_result_t;

  localparam logic [StateW-1:0] MixMult = {MixMultHi, MixMultLo};
  localparam logic [WordW-1:0]  WordMax = '1;

  // shadow copy of the generator
  logic [StateW-1:0] gen_state;
  logic [WordW-1:0]  seed_reg;
  logic [WordW-1:0]  call_ctr;

  draw_result_t awaited_draws[$];
  int           mismatch_count = 0;
  int           results_seen   = 0;

  function automatic logic [WordW-1:0] next_draw();
    logic [StateW-1:0] s;
    logic [StateW-1:0] prod;
    s = gen_state;
    s = s ^ (s >> ShiftA);
    s = s ^ (s << ShiftB);
    s = s ^ (s >> ShiftC);
    gen_state = s;
    call_ctr  = call_ctr + 1'b1;
    prod      = s * MixMult;
    return prod[StateW-1:WordW];
  endfunction

  function automatic void load_seed(input logic [WordW-1:0] sd);
    logic [WordW-1:0] discard;
    seed_reg  = (sd == '0) ? 32'd1 : sd;
    gen_state = {32'd0, seed_reg};
    for (int n = 0; n < WarmupSteps; n++) discard = next_draw();
    call_ctr = '0;
  endfunction

  function automatic logic [WordW-1:0] ranged_draw(input logic [WordW-1:0] lo,
                                                   input logic [WordW-1:0] hi);
    logic [WordW-1:0] span;
    logic [WordW-1:0] limit;
    logic [WordW-1:0] r;
    if (lo >= hi) return lo;
    span  = hi - lo;
    limit = WordMax - (WordMax % span);
    r = next_draw();
    while (r >= limit) r = next_draw();
    return lo + (r % span);
  endfunction

  task automatic report_mismatch(input string what, input logic [StateW-1:0] got,
                                 input logic [StateW-1:0] want);
    $display("[%0t] mismatch in %s at result %0d: got %h, expected %h",
             $realtime, what, results_seen, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_result_t exp_res;
    draw_result_t new_res;
    if (!rst_ni) begin
      load_seed(32'd1);
      awaited_draws.delete();
    end else begin
      // results first, so a request taken at the same edge queues behind
      if (out_valid_i && !out_stall_i) begin
        if (awaited_draws.size() == 0) begin
          report_mismatch("unexpected result", state_hash_i, '0);
        end else begin
          exp_res = awaited_draws.pop_front();
          if (value_i !== exp_res.value)
            report_mismatch("value", {32'd0, value_i}, {32'd0, exp_res.value});
          if (state_hash_i !== exp_res.hash)
            report_mismatch("state hash", state_hash_i, exp_res.hash);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        new_res.value = '0;
        case (kind_i)
          KIND_RESEED: begin
            load_seed(seed_value_i);
          end
          KIND_RAW: begin
            new_res.value = next_draw();
          end
          KIND_RANGE: begin
            new_res.value = ranged_draw(range_low_i, range_high_i);
          end
          default: begin
            // unused kind leaves everything alone
          end
        endcase
        new_res.hash = gen_state ^ {seed_reg, 32'd0} ^ {32'd0, call_ctr};
        awaited_draws.push_back(new_res);
      end
    end
    fail_count_o <= mismatch_count;
    pending_o    <= awaited_draws.size();
    checked_o    <= results_seen;
  end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// testbench top for the xorshift64* range generator: stimulus, receiver stalls and verdict
`default_nettype none

module tb_top import xrg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // the package has no name for the spare kind code
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int PhaseCount    = 4;
  localparam int PhaseRequests = 450;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 120;
  // slowest run: ~1800 requests, most of them ranged draws with many redraws, full stalls and gaps
  localparam int CycleLimit    = 2_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic [1:0]       kind       = KIND_RAW;
  logic [WordW-1:0] seed_value = '0;
  logic [WordW-1:0] range_low  = '0;
  logic [WordW-1:0] range_high = '0;

  // result channel
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WordW-1:0]  value;
  logic [StateW-1:0] state_hash;

  // receiver behaviour, set per phase by the stimulus process
  logic [1:0] stall_mode = 2'd0;
  int         hold_token = 0;
  int         hold_seen  = 0;
  int         hold_left  = 0;
  int         stall_tick = 0;

  int cycle_count = 0;
  int fail_count;
  int pending;
  int checked;

  // what the stimulus actually offered, for the summary
  int n_reseed = 0;
  int n_raw    = 0;
  int n_range  = 0;
  int n_empty  = 0;
  int n_unused = 0;

  always #5 clk_i = ~clk_i;

  xorshift64star_range_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .seed_value_i (seed_value),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_o      (value),
    .state_hash_o (state_hash)
  );

  xrg_draw_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .kind_i       (kind),
    .seed_value_i (seed_value),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .value_i      (value),
    .state_hash_i (state_hash),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("xorshift64star_range_generator regression: fail");
      $finish;
    end
  end

  // receiver stall pattern; a long hold-off starts whenever the token moves
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HoldOffCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        2'd0: begin
          out_stall <= 1'b0;
        end
        2'd1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2'd2: begin
          // periodic pattern, drifts against the block's own cadence
          out_stall <= ((stall_tick % 7) < 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // offer one request and hold it until the block takes it
  task automatic push_request(input logic [1:0] k, input logic [WordW-1:0] sd,
                              input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
    in_valid   <= 1'b1;
    kind       <= k;
    seed_value <= sd;
    range_low  <= lo;
    range_high <= hi;
    case (k)
      KIND_RESEED: n_reseed++;
      KIND_RAW:    n_raw++;
      KIND_RANGE: begin
        n_range++;
        if (lo >= hi) n_empty++;
      end
      default:     n_unused++;
    endcase
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic sender_pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // one random request; fields a kind does not use are random as well
  task automatic random_request(output bit counted);
    int               pick;
    int               shape;
    logic [1:0]       k;
    logic [WordW-1:0] sd;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 7);
    sd    = $urandom;
    lo    = $urandom;
    hi    = $urandom;
    if (pick < 8) begin
      k = KIND_RESEED;
      // zero seed and all-ones seed now and then
      if ($urandom_range(0, 9) == 0) sd = $urandom_range(0, 1) ? '1 : '0;
    end else if (pick < 38) begin
      k = KIND_RAW;
    end else if (pick < 95) begin
      k = KIND_RANGE;
      case (shape)
        0: begin
          // fully random bounds, empty about half the time
        end
        1: hi = lo + $urandom_range(1, 16);
        2: begin
          lo = $urandom_range(0, 1000);
          hi = lo + $urandom_range(1, 1 << 20);
        end
        3: lo = '0;
        4: begin
          // span just above half the word, heavy redraw rate
          lo = $urandom_range(0, 100);
          hi = lo + 32'h8000_0000 + $urandom_range(0, 1000);
        end
        5: hi = lo;
        6: hi = '1;
        default: begin
          lo = $urandom_range(0, 10);
          hi = lo + $urandom_range(1, 3);
        end
      endcase
    end else begin
      k = KindUnused;
    end
    push_request(k, sd, lo, hi);
    counted = (k != KindUnused);
  endtask

  initial begin : stimulus
    int issued;
    int burst;
    int gap;
    bit counted;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: reset state, seed extremes, range extremes and the odd kinds
    push_request(KIND_RAW,    $urandom, $urandom, $urandom);
    push_request(KIND_RANGE,  $urandom, 32'd0, 32'd1);
    push_request(KIND_RESEED, 32'd0, $urandom, $urandom);
    push_request(KIND_RAW,    $urandom, $urandom, $urandom);
    push_request(KIND_RESEED, 32'hFFFF_FFFF, $urandom, $urandom);
    push_request(KIND_RAW,    $urandom, $urandom, $urandom);
    push_request(KIND_RANGE,  $urandom, 32'd0, 32'hFFFF_FFFF);
    push_request(KIND_RANGE,  $urandom, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_request(KIND_RANGE,  $urandom, 32'd5, 32'd5);
    push_request(KIND_RANGE,  $urandom, 32'hFFFF_FFFF, 32'd0);
    push_request(KIND_RANGE,  $urandom, 32'd0, 32'h8000_0001);
    push_request(KIND_RANGE,  $urandom, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_request(KindUnused,  $urandom, $urandom, $urandom);
    push_request(KindUnused,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(KIND_RESEED, 32'h1234_5678, $urandom, $urandom);
    push_request(KIND_RAW,    32'd0, 32'd0, 32'd0);
    push_request(KIND_RANGE,  $urandom, 32'd100, 32'd200);
    push_request(KIND_RANGE,  $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random part: phase 0 runs flat out, later phases add gaps and stalls
    for (int phase = 0; phase < PhaseCount; phase++) begin
      stall_mode <= phase[1:0];
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) hold_token <= hold_token + 1;
      issued = 0;
      while (issued < PhaseRequests) begin
        burst = (phase == 0) ? 50 : $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          random_request(counted);
          if (counted) issued++;
        end
        gap = (phase == 0) ? 0 : $urandom_range(0, 10);
        if (phase == 2 && issued < 40) gap = 0;
        sender_pause(gap);
      end
    end
    in_valid <= 1'b0;

    // the checker's count is a registered copy of its queue size
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d reseeds, %0d raw draws, %0d ranged draws (%0d empty), %0d unused",
             n_reseed, n_raw, n_range, n_empty, n_unused);
    $display("compared %0d results in %0d cycles, %0d mismatches",
             checked, cycle_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("xorshift64star_range_generator regression: pass");
    end else begin
      $display("xorshift64star_range_generator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/xrg_pkg.sv
sv/xrg_datapath.sv
sv/xrg_ctrl.sv
sv/xorshift64star_range_generator.sv
bench/xrg_draw_checker.sv
bench/tb_top.sv
